/* src/vdm_pkg.sv */
// package: payload structs, status codes and controller/datapath command types
`timescale 1ns / 1ps
package vdm_pkg;

  localparam int unsigned DataW = 32;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_EQUAL = 2'd1,
    STATUS_SAT   = 2'd2
  } status_e;

  typedef struct packed {
    logic signed [31:0] node_value;
    logic signed [31:0] value_real;
    logic signed [31:0] value_imag;
  } in_beat_t;

  typedef struct packed {
    logic signed [31:0] coef_real;
    logic signed [31:0] coef_imag;
    logic [3:0]         coef_index;
    logic               last;
    logic [1:0]         status;
  } out_beat_t;

  // datapath operations issued by the controller
  typedef enum logic [2:0] {
    OP_NONE  = 3'd0,
    OP_LOAD  = 3'd1,
    OP_CMP   = 3'd2,
    OP_DIV   = 3'd3,
    OP_MUL   = 3'd4,
    OP_CLEAR = 3'd5
  } op_e;

  typedef struct packed {
    op_e        op;
    logic [3:0] idx_a;   // destination / first operand index
    logic [3:0] idx_b;   // second operand index
    logic [3:0] idx_x;   // node index
    logic       start;   // pulse: begin op
  } cmd_t;

  typedef struct packed {
    logic done;          // op finished
    logic equal;         // compare found equal nodes
  } sts_t;

endpackage

/* src/vdm_datapath.sv */
// datapath: stores, shared iterative divider, registered multiplier, saturation
`timescale 1ns / 1ps
module vdm_datapath import vdm_pkg::*; #(
  parameter int unsigned Order = 3
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cmd_t       cmd_i,
  input  in_beat_t   load_i,
  output sts_t       sts_o,
  output logic       sat_o,
  output logic signed [31:0] rd_real_o,
  output logic signed [31:0] rd_imag_o,
  input  logic [3:0] rd_idx_i
);

  localparam int unsigned IdxW = (Order > 1) ? $clog2(Order) : 1;

  logic signed [31:0] node_q [Order];
  logic signed [31:0] wre_q  [Order];
  logic signed [31:0] wim_q  [Order];

  // iteration state
  logic [5:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic        sat_q, sat_d;
  logic        equal_q, equal_d;
  logic [49:0] rem_re_q, rem_re_d, rem_im_q, rem_im_d;
  logic [48:0] nre_q, nre_d, nim_q, nim_d;
  logic [48:0] qre_q, qre_d, qim_q, qim_d;
  logic [32:0] den_q, den_d;
  logic        neg_re_q, neg_re_d, neg_im_q, neg_im_d;
  logic [63:0] pre_q, pre_d, pim_q, pim_d;

  logic [IdxW-1:0] ia, ib, ix;
  assign ia = cmd_i.idx_a[IdxW-1:0];
  assign ib = cmd_i.idx_b[IdxW-1:0];
  assign ix = cmd_i.idx_x[IdxW-1:0];

  function automatic logic [32:0] mag33(input logic signed [32:0] v);
    mag33 = v[32] ? 33'(-v) : v;
  endfunction

  // saturate 66-bit signed to 32 bits
  function automatic logic signed [31:0] sat_fn(input logic signed [65:0] v,
                                                 output logic s);
    s = 1'b0;
    if (v > 66'sd2147483647) begin
      s = 1'b1;
      sat_fn = 32'h7fffffff;
    end else if (v < -66'sd2147483648) begin
      s = 1'b1;
      sat_fn = 32'h80000000;
    end else begin
      sat_fn = v[31:0];
    end
  endfunction

  logic signed [32:0] dsub, nrsub, nisub;
  logic [32:0] dmag;
  logic [31:0] xmag, amre, amim;
  logic signed [65:0] rq_re, rq_im, mr_re, mr_im;
  logic signed [31:0] sv_re, sv_im;
  logic s_re, s_im;
  logic [49:0] trial_re, trial_im;
  logic [63:0] pr_re, pr_im;
  logic signed [31:0] xs;

  always_comb begin
    dsub  = 33'(node_q[ia]) - 33'(node_q[ib]);
    nrsub = 33'(wre_q[ia]) - 33'(wre_q[ia-1'b1]);
    nisub = 33'(wim_q[ia]) - 33'(wim_q[ia-1'b1]);
    dmag  = mag33(dsub);
    xs    = node_q[ix];
    xmag  = xs[31] ? 32'(-xs) : 32'(xs);
    amre  = wre_q[ib][31] ? 32'(-wre_q[ib]) : 32'(wre_q[ib]);
    amim  = wim_q[ib][31] ? 32'(-wim_q[ib]) : 32'(wim_q[ib]);
    trial_re = {rem_re_q[48:0], nre_q[48]};
    trial_im = {rem_im_q[48:0], nim_q[48]};
    pr_re = (pre_q + 64'h8000) >> 16;
    pr_im = (pim_q + 64'h8000) >> 16;
    rq_re = neg_re_q ? -$signed({17'd0, qre_q}) : $signed({17'd0, qre_q});
    rq_im = neg_im_q ? -$signed({17'd0, qim_q}) : $signed({17'd0, qim_q});
    mr_re = 66'(wre_q[ia]) - (neg_re_q ? -$signed({2'd0, pr_re}) : $signed({2'd0, pr_re}));
    mr_im = 66'(wim_q[ia]) - (neg_im_q ? -$signed({2'd0, pr_im}) : $signed({2'd0, pr_im}));
    sv_re = sat_fn(cmd_i.op == OP_DIV ? rq_re : mr_re, s_re);
    sv_im = sat_fn(cmd_i.op == OP_DIV ? rq_im : mr_im, s_im);
  end

  // sequencing of multi-cycle ops
  always_comb begin
    cnt_d = cnt_q; busy_d = busy_q; done_d = 1'b0; sat_d = sat_q; equal_d = equal_q;
    rem_re_d = rem_re_q; rem_im_d = rem_im_q; nre_d = nre_q; nim_d = nim_q;
    qre_d = qre_q; qim_d = qim_q; den_d = den_q;
    neg_re_d = neg_re_q; neg_im_d = neg_im_q; pre_d = pre_q; pim_d = pim_q;
    if (cmd_i.start) begin
      unique case (cmd_i.op)
        OP_CMP: begin
          if (node_q[ia] == node_q[ib]) equal_d = 1'b1;
          done_d = 1'b1;
        end
        OP_DIV: begin
          // n = |num|<<16 + |d|/2 ; restoring division, 49 bits
          nre_d = 49'({mag33(nrsub), 16'd0}) + 49'(dmag >> 1);
          nim_d = 49'({mag33(nisub), 16'd0}) + 49'(dmag >> 1);
          neg_re_d = nrsub[32] ^ dsub[32];
          neg_im_d = nisub[32] ^ dsub[32];
          den_d = dmag; rem_re_d = '0; rem_im_d = '0;
          cnt_d = 6'd49; busy_d = 1'b1;
        end
        OP_MUL: begin
          pre_d = 64'(amre) * 64'(xmag);
          pim_d = 64'(amim) * 64'(xmag);
          neg_re_d = wre_q[ib][31] ^ xs[31];
          neg_im_d = wim_q[ib][31] ^ xs[31];
          cnt_d = 6'd1; busy_d = 1'b1;
        end
        OP_CLEAR: begin
          equal_d = 1'b0; sat_d = 1'b0; done_d = 1'b1;
        end
        default: done_d = 1'b1;
      endcase
    end else if (busy_q) begin
      if (cmd_i.op == OP_DIV && cnt_q != 6'd0) begin
        nre_d = {nre_q[47:0], 1'b0};
        nim_d = {nim_q[47:0], 1'b0};
        if (trial_re >= 50'(den_q)) begin
          rem_re_d = trial_re - 50'(den_q); qre_d = {qre_q[47:0], 1'b1};
        end else begin
          rem_re_d = trial_re; qre_d = {qre_q[47:0], 1'b0};
        end
        if (trial_im >= 50'(den_q)) begin
          rem_im_d = trial_im - 50'(den_q); qim_d = {qim_q[47:0], 1'b1};
        end else begin
          rem_im_d = trial_im; qim_d = {qim_q[47:0], 1'b0};
        end
        cnt_d = cnt_q - 6'd1;
      end else begin
        busy_d = 1'b0; done_d = 1'b1;
        if (s_re || s_im) sat_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0; busy_q <= 1'b0; done_q <= 1'b0; sat_q <= 1'b0; equal_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d; busy_q <= busy_d; done_q <= done_d;
      sat_q <= sat_d; equal_q <= equal_d;
    end
  end

  // payload registers and stores
  always_ff @(posedge clk_i) begin
    rem_re_q <= rem_re_d; rem_im_q <= rem_im_d; nre_q <= nre_d; nim_q <= nim_d;
    qre_q <= cmd_i.start ? 49'd0 : qre_d; qim_q <= cmd_i.start ? 49'd0 : qim_d;
    den_q <= den_d; neg_re_q <= neg_re_d; neg_im_q <= neg_im_d;
    pre_q <= pre_d; pim_q <= pim_d;
    if (cmd_i.start && cmd_i.op == OP_LOAD) begin
      node_q[ia] <= load_i.node_value;
      wre_q[ia]  <= load_i.value_real;
      wim_q[ia]  <= load_i.value_imag;
    end
    if (!cmd_i.start && busy_q && (cmd_i.op == OP_MUL ||
        (cmd_i.op == OP_DIV && cnt_q == 6'd0))) begin
      wre_q[ia] <= sv_re;
      wim_q[ia] <= sv_im;
    end
  end

  assign sts_o.done  = done_q;
  assign sts_o.equal = equal_q;
  assign sat_o       = sat_q;
  assign rd_real_o   = wre_q[rd_idx_i[IdxW-1:0]];
  assign rd_imag_o   = wim_q[rd_idx_i[IdxW-1:0]];

endmodule

/* src/vdm_ctrl.sv */
// controller: load, compare, divided differences, nested update, emission
`timescale 1ns / 1ps
module vdm_ctrl import vdm_pkg::*; #(
  parameter int unsigned Order = 3
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [3:0] out_idx_o,
  output logic       out_last_o,
  output logic [1:0] out_status_o,
  output cmd_t       cmd_o,
  input  sts_t       sts_i,
  input  logic       sat_i,
  output logic [3:0] rd_idx_o
);

  typedef enum logic [2:0] {
    S_LOAD, S_CMP, S_DIV, S_MUL, S_EMIT, S_WAIT
  } state_e;

  localparam logic [3:0] Last = 4'(Order - 1);

  state_e     state_q, ret_q;
  logic [3:0] cnt_q, i_q, j_q, k_q;
  logic       start_q, valid_q;
  op_e        op_q;
  logic [1:0] st_q;

  assign in_stall_o   = (state_q != S_LOAD);
  assign out_valid_o  = valid_q;
  assign out_idx_o    = i_q;
  assign out_last_o   = (i_q == Last);
  assign out_status_o = st_q;
  assign rd_idx_o     = i_q;
  assign cmd_o.op     = op_q;
  assign cmd_o.idx_a  = i_q;
  assign cmd_o.idx_b  = (op_q == OP_MUL) ? 4'(i_q + 4'd1) :
                        (op_q == OP_DIV) ? 4'(i_q - k_q - 4'd1) : j_q;
  assign cmd_o.idx_x  = k_q;
  assign cmd_o.start  = start_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_LOAD; ret_q <= S_LOAD; cnt_q <= '0; i_q <= '0; j_q <= '0;
      k_q <= '0; start_q <= 1'b0; valid_q <= 1'b0; op_q <= OP_NONE; st_q <= STATUS_OK;
    end else begin
      start_q <= 1'b0;
      unique case (state_q)
        S_LOAD: begin
          op_q <= OP_LOAD;
          if (in_valid_i) begin
            i_q <= cnt_q; start_q <= 1'b1;
            if (cnt_q == Last) begin
              cnt_q <= '0; state_q <= S_WAIT; ret_q <= S_CMP;
            end else begin
              cnt_q <= cnt_q + 4'd1;
            end
          end
        end
        // one compare per node pair, after the load beat settles
        S_WAIT: begin
          if (!start_q) begin
            state_q <= ret_q;
            if (ret_q == S_CMP) begin
              op_q <= OP_CLEAR; start_q <= 1'b1;
              i_q <= 4'd1; j_q <= 4'd0;
            end
          end
        end
        S_CMP: begin
          if (op_q == OP_CLEAR && sts_i.done) begin
            op_q <= OP_CMP; start_q <= 1'b1;
          end else if (op_q == OP_CMP && sts_i.done) begin
            if (j_q + 4'd1 < i_q) begin
              j_q <= j_q + 4'd1; start_q <= 1'b1;
            end else if (i_q < Last) begin
              i_q <= i_q + 4'd1; j_q <= '0; start_q <= 1'b1;
            end else if (sts_i.equal) begin
              st_q <= STATUS_EQUAL; i_q <= '0; valid_q <= 1'b1; state_q <= S_EMIT;
            end else begin
              op_q <= OP_DIV; k_q <= '0; i_q <= Last; start_q <= 1'b1; state_q <= S_DIV;
            end
          end
        end
        // divided differences: k up, i down to k+1
        S_DIV: begin
          if (sts_i.done) begin
            if (i_q > k_q + 4'd1) begin
              i_q <= i_q - 4'd1; start_q <= 1'b1;
            end else if (k_q + 4'd1 < Last) begin
              k_q <= k_q + 4'd1; i_q <= Last; start_q <= 1'b1;
            end else begin
              op_q <= OP_MUL; k_q <= Last - 4'd1; i_q <= Last - 4'd1;
              start_q <= 1'b1; state_q <= S_MUL;
            end
          end
        end
        // nested update: k down, i from k up to Order-2
        S_MUL: begin
          if (sts_i.done) begin
            if (i_q + 4'd1 < Last) begin
              i_q <= i_q + 4'd1; start_q <= 1'b1;
            end else if (k_q != 4'd0) begin
              k_q <= k_q - 4'd1; i_q <= k_q - 4'd1; start_q <= 1'b1;
            end else begin
              st_q <= sat_i ? STATUS_SAT : STATUS_OK;
              op_q <= OP_NONE; i_q <= '0; valid_q <= 1'b1; state_q <= S_EMIT;
            end
          end
        end
        S_EMIT: begin
          if (!out_stall_i) begin
            if (i_q == Last) begin
              valid_q <= 1'b0; i_q <= '0; state_q <= S_LOAD; op_q <= OP_LOAD;
            end else begin
              i_q <= i_q + 4'd1;
            end
          end
        end
        default: state_q <= S_LOAD;
      endcase
    end
  end

endmodule

/* src/vandermonde_solver.sv */
// top level: Vandermonde solver, controller plus datapath
`timescale 1ns / 1ps
// Takes ORDER beats (node, complex value) and then, after the solve, gives ORDER
// coefficient beats in index order with last on the final one. Input beats can
// follow back to back while a run loads. The solve is serial on one datapath:
// compares of each node pair, ORDER*(ORDER-1)/2 divisions on one restoring divider
// (49 quotient bits), the multiplies of the nested update, and one output beat
// per cycle while out_stall_i is low, plus load and clear steps; the run time is
// set mostly by the divisions. Input is stalled from the last load beat until
// the last coefficient is taken. Equal nodes give status 1 and zero
// coefficients; any clamp gives status 2 on the whole run.
module vandermonde_solver import vdm_pkg::*; #(
  parameter int unsigned ORDER = 3
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_beat_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_beat_t out_data_o
);

  cmd_t cmd;
  sts_t sts;
  logic sat;
  logic signed [31:0] rd_re, rd_im;
  logic [3:0] rd_idx, oidx;
  logic olast;
  logic [1:0] ost;
  in_beat_t load_q;

  // hold the accepted input beat for the load command that follows it
  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      load_q <= in_data_i;
    end
  end

  vdm_ctrl #(.Order(ORDER)) u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .out_valid_o, .out_stall_i,
    .out_idx_o(oidx), .out_last_o(olast), .out_status_o(ost),
    .cmd_o(cmd), .sts_i(sts), .sat_i(sat), .rd_idx_o(rd_idx)
  );

  vdm_datapath #(.Order(ORDER)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .load_i(load_q), .sts_o(sts), .sat_o(sat),
    .rd_real_o(rd_re), .rd_imag_o(rd_im), .rd_idx_i(rd_idx)
  );

  // equal nodes force zero coefficients
  always_comb begin
    out_data_o.coef_real  = (ost == STATUS_EQUAL) ? '0 : rd_re;
    out_data_o.coef_imag  = (ost == STATUS_EQUAL) ? '0 : rd_im;
    out_data_o.coef_index = oidx;
    out_data_o.last       = olast;
    out_data_o.status     = ost;
  end

endmodule

/* src/vdm_checker.sv */
// checker: port-level properties of the solver, bound to the top level
`timescale 1ns / 1ps
module vdm_assertions import vdm_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_stall_o,
  input logic      out_valid_o,
  input logic      out_stall_i,
  input out_beat_t out_data_o
);

  // no input beat is taken while results are offered
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o) else $error("input open during emission");

  // stalled result beat holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("result beat changed under stall");

  // status is never the unused code
  a_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.status != 2'd3) else $error("bad status");

  // index steps by one within a run
  a_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !out_data_o.last |=>
      out_valid_o && out_data_o.coef_index == 4'($past(out_data_o.coef_index) + 4'd1))
    else $error("coefficient index skipped");

endmodule

bind vandermonde_solver vdm_assertions u_vdm_assertions (
  .clk_i, .rst_ni, .in_stall_o, .out_valid_o, .out_stall_i, .out_data_o
);
